// File: design/assert_macros.svh
// Assertion macros shared by the velocity reduction factor RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VRF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("vrf check failed");
`define VRF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("vrf check failed");
`else
`define VRF_ASSERT_IMP(label, clk, rst, a, c)
`define VRF_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: design/vrf_pkg.sv
// Types, segment codes, breakpoints and polynomial tables (Q.30).
// No dependencies; imported by every vrf module.
`timescale 1ns / 1ps
package vrf_pkg;
  localparam int QB    = 30;
  localparam int ACC_W = 36;
  localparam int Y_W   = 32;
  localparam int TAU_W = 34;
  localparam int QW    = 33;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [Y_W-1:0]   y_t;
  typedef logic signed [TAU_W-1:0] ctr_t;

  typedef enum logic [2:0] {SEG_LOW, SEG_MID, SEG_R3, SEG_R4, SEG_R5, SEG_FAR} seg_t;

  localparam logic [TAU_W-1:0] BP1 = 34'd616730209;
  localparam logic [TAU_W-1:0] BP2 = 34'd1610612736;
  localparam logic [TAU_W-1:0] BP3 = 34'd2684354560;
  localparam logic [TAU_W-1:0] BP4 = 34'd5657231867;
  localparam logic [TAU_W-1:0] BP5 = 34'd12252549135;
  localparam acc_t Q_ONE = 36'sd1073741824;

  localparam acc_t POLY1 [5] = '{36'sd1073741824, -36'sd536870912, 36'sd178956971,
                                 -36'sd44739243, 36'sd8947849};
  localparam acc_t POLY2 [5] = '{36'sd678734282, 36'sd395007542, -36'sd197503771,
                                 36'sd65835924, -36'sd16458981};
  localparam acc_t POLY3 [5] = '{36'sd464213335, 36'sd637796362, -36'sd581260615,
                                 36'sd387507077, 36'sd0};
  localparam acc_t POLY4 [5] = '{36'sd297519323, 36'sd927832953, -36'sd695093649,
                                 -36'sd405471295, 36'sd2660905376};
  localparam acc_t POLY5 [5] = '{36'sd134172703, 36'sd1070500022, -36'sd92211265,
                                 -36'sd1229483533, -36'sd5901520961};

  function automatic acc_t coef(seg_t seg, logic [2:0] k);
    acc_t c;
    case (seg)
      SEG_LOW: c = POLY1[k];
      SEG_MID: c = POLY2[k];
      SEG_R3:  c = POLY3[k];
      SEG_R4:  c = POLY4[k];
      SEG_R5:  c = POLY5[k];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic ctr_t centre(seg_t seg);
    ctr_t c;
    case (seg)
      SEG_R3:  c = 34'sd536870912;
      SEG_R4:  c = 34'sd306783378;
      SEG_R5:  c = 34'sd134217728;
      default: c = '0;
    endcase
    return c;
  endfunction
endpackage

// File: design/vrf_in_if.sv
// Input channel: sigma and ds with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface vrf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sigma;
  logic [31:0] ds;
  modport source(output valid, sigma, ds, input ready);
  modport sink(input valid, sigma, ds, output ready);
endinterface

// File: design/vrf_out_if.sv
// Result channel: alpha with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface vrf_out_if #(parameter int ALPHA_W = 17);
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha;
  modport source(output valid, alpha, input ready);
  modport sink(input valid, alpha, output ready);
endinterface

// File: design/vrf_horner.sv
// Pipelined quartic evaluation in Horner form, Q.30, rounded products.
// Depends on vrf_pkg. One multiply stage and one add stage per step.
`timescale 1ns / 1ps
module vrf_horner #(
  parameter int SB_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vrf_pkg::y_t         y,
  input  vrf_pkg::seg_t       seg,
  input  logic [SB_W-1:0]     sb,
  output logic                out_valid,
  output vrf_pkg::acc_t       acc,
  output logic [SB_W-1:0]     sb_out
);
  import vrf_pkg::*;
  localparam int STEPS = 4;

  logic            v_a   [STEPS+1];
  acc_t            acc_a [STEPS+1];
  logic [SB_W-1:0] sb_a  [STEPS+1];
  y_t              y_a   [STEPS];
  seg_t            seg_a [STEPS];
  logic            v_m   [STEPS];
  logic [63:0]     mag_m [STEPS];
  logic            neg_m [STEPS];
  seg_t            seg_m [STEPS];
  logic [SB_W-1:0] sb_m  [STEPS];
  y_t              y_m   [STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a[0] <= 1'b0;
    end else if (en) begin
      v_a[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_a[0] <= coef(seg, 3'(STEPS));
      y_a[0]   <= y;
      seg_a[0] <= seg;
      sb_a[0]  <= sb;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [ACC_W-1:0]     am;
    logic [Y_W-1:0]       ym;
    logic [ACC_W+Y_W-1:0] pr;
    logic [64:0]          rs;
    logic [ACC_W-1:0]     m;
    acc_t                 sm;

    always_comb begin
      am = acc_a[j][ACC_W-1] ? ACC_W'(-acc_a[j]) : ACC_W'(acc_a[j]);
      ym = y_a[j][Y_W-1] ? Y_W'(-y_a[j]) : Y_W'(y_a[j]);
      pr = am * ym;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_m[j] <= 1'b0;
      end else if (en) begin
        v_m[j] <= v_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_m[j] <= pr[63:0];
        neg_m[j] <= acc_a[j][ACC_W-1] ^ y_a[j][Y_W-1];
        seg_m[j] <= seg_a[j];
        sb_m[j]  <= sb_a[j];
      end
    end

    if (j < STEPS - 1) begin : g_ycarry
      always_ff @(posedge clk) begin
        if (en) begin
          y_m[j]       <= y_a[j];
          y_a[j+1]     <= y_m[j];
          seg_a[j+1]   <= seg_m[j];
        end
      end
    end

    always_comb begin
      rs = {1'b0, mag_m[j]} + 65'(64'd1 << (QB - 1));
      m  = ACC_W'(rs >> QB);
      sm = neg_m[j] ? -signed'(m) : signed'(m);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[j+1] <= 1'b0;
      end else if (en) begin
        v_a[j+1] <= v_m[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_a[j+1] <= sm + coef(seg_m[j], 3'(STEPS - 1 - j));
        sb_a[j+1]  <= sb_m[j];
      end
    end
  end

  assign out_valid = v_a[STEPS];
  assign acc       = acc_a[STEPS];
  assign sb_out    = sb_a[STEPS];
endmodule

// File: design/vrf_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64-bit operands.
// Depends on vrf_pkg for the quotient width.
`timescale 1ns / 1ps
module vrf_div #(
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          num,
  input  logic [63:0]          den,
  input  logic [SB_W-1:0]      sb,
  output logic                 out_valid,
  output logic [vrf_pkg::QW-1:0] quo,
  output logic [SB_W-1:0]      sb_out
);
  import vrf_pkg::*;
  localparam int W = 64 + QW;

  logic            v_s   [QW+1];
  logic [63:0]     rem_s [QW+1];
  logic [63:0]     den_s [QW+1];
  logic [QW-1:0]   q_s   [QW+1];
  logic [SB_W-1:0] sb_s  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= num;
      den_s[0] <= den;
      q_s[0]   <= '0;
      sb_s[0]  <= sb;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int K = QW - 1 - j;
    logic [W-1:0] dsh;
    logic         ge;

    always_comb begin
      dsh = W'(den_s[j]) << K;
      ge  = W'(rem_s[j]) >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1] <= ge ? rem_s[j] - dsh[63:0] : rem_s[j];
        den_s[j+1] <= den_s[j];
        q_s[j+1]   <= {q_s[j][QW-2:0], ge};
        sb_s[j+1]  <= sb_s[j];
      end
    end
  end

  assign out_valid = v_s[QW];
  assign quo       = q_s[QW];
  assign sb_out    = sb_s[QW];
endmodule

// File: design/vrf_sqrt.sv
// Pipelined digit-by-digit square root with round to nearest.
// Depends on vrf_pkg only through the common import convention.
`timescale 1ns / 1ps
module vrf_sqrt #(
  parameter int RB   = 17,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RB-2:0]   v,
  input  logic [SB_W-1:0]   sb,
  output logic              out_valid,
  output logic [RB-1:0]     root,
  output logic [SB_W-1:0]   sb_out
);
  import vrf_pkg::*;
  localparam int VW = 2 * RB - 1;
  localparam int TW = VW + 2;

  logic            v_s    [RB+1];
  logic [VW-1:0]   rem_s  [RB+1];
  logic [RB-1:0]   root_s [RB+1];
  logic [SB_W-1:0] sb_s   [RB+1];
  logic            v_o;
  logic [RB-1:0]   root_o;
  logic [SB_W-1:0] sb_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= v;
      root_s[0] <= '0;
      sb_s[0]   <= sb;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_bit
    localparam int B = RB - 1 - j;
    logic [TW-1:0] t;
    logic          ge;

    always_comb begin
      t  = (TW'(root_s[j]) << (B + 1)) + (TW'(1) << (2 * B));
      ge = TW'(rem_s[j]) >= t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else if (en) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1]  <= ge ? rem_s[j] - t[VW-1:0] : rem_s[j];
        root_s[j+1] <= ge ? (root_s[j] | (RB'(1) << B)) : root_s[j];
        sb_s[j+1]   <= sb_s[j];
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_s[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_o <= root_s[RB] + RB'(rem_s[RB] > VW'(root_s[RB]));
      sb_o   <= sb_s[RB];
    end
  end

  assign out_valid = v_o;
  assign root      = root_o;
  assign sb_out    = sb_o;
endmodule

// File: design/velocity_reduction_factor_core.sv
// Pipeline: 4 front-end stages, two 9-stage
// Horner units, a 34-stage divider, an (OUT_FRAC_BITS+3)-stage square root, output register.
// Throughput: one transfer per cycle; the whole pipeline holds while a result is not taken.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Depends on vrf_pkg, vrf_in_if, vrf_out_if, vrf_horner, vrf_div, vrf_sqrt.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module velocity_reduction_factor_core #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  vrf_in_if.sink    item,
  vrf_out_if.source result
);
  import vrf_pkg::*;

  localparam int ALPHA_W = OUT_FRAC_BITS + 1;
  localparam int SH      = 2 * IN_FRAC_BITS - QB;
  localparam int SQ_S    = 2 * OUT_FRAC_BITS - QB;
  localparam int VW      = 2 * OUT_FRAC_BITS + 1;
  localparam logic [63:0] U64_MAX = '1;
  localparam logic [ALPHA_W-1:0] ONE_A = ALPHA_W'(1) << OUT_FRAC_BITS;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << OUT_FRAC_BITS;
  localparam int SB1_W = 3 + 64 + TAU_W;
  localparam int SBD_W = 3 + TAU_W;
  localparam int SBF_W = 1 + ALPHA_W;
  localparam int SB2_W = 1 + QW + SBF_W;

  logic adv;
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  // front end: product, x, x squared, tau and segment
  logic              v1, v2, v3, v4;
  logic [63:0]       p1, x2, x3, x4, sq3, x_next, sq_next;
  logic              big3;
  logic [64:0]       sq_sum;
  logic [TAU_W-1:0]  tau_next, tau4;
  seg_t              seg_next, seg4;

  if (SH >= 0) begin : g_rs
    localparam logic [63:0] LIM = U64_MAX / 64'd10;
    logic [63:0] q;
    assign q      = p1 >> SH;
    assign x_next = (q > LIM) ? U64_MAX : (q << 3) + (q << 1);
  end else begin : g_ls
    localparam int LS = -SH;
    localparam logic [63:0] LIM = (U64_MAX / 64'd10) >> LS;
    assign x_next = (p1 > LIM) ? U64_MAX : ((p1 << 3) + (p1 << 1)) << LS;
  end

  assign sq_next  = x2[31:0] * x2[31:0];
  assign sq_sum   = {1'b0, sq3} + 65'(64'd1 << (QB - 1));
  assign tau_next = sq_sum[QB+TAU_W-1:QB];

  always_comb begin
    if (big3 || tau_next >= BP5) begin
      seg_next = SEG_FAR;
    end else if (tau_next < BP1) begin
      seg_next = SEG_LOW;
    end else if (tau_next < BP2) begin
      seg_next = SEG_MID;
    end else if (tau_next < BP3) begin
      seg_next = SEG_R3;
    end else if (tau_next < BP4) begin
      seg_next = SEG_R4;
    end else begin
      seg_next = SEG_R5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1   <= item.sigma * item.ds;
      x2   <= x_next;
      sq3  <= sq_next;
      x3   <= x2;
      big3 <= |x2[63:32];
      tau4 <= tau_next;
      x4   <= x3;
      seg4 <= seg_next;
    end
  end

  // numerator polynomial of the middle segment, in 1 - tau
  logic signed [TAU_W:0] d1;
  y_t                    y1;
  logic                  vh1;
  acc_t                  n_h1;
  logic [SB1_W-1:0]      sb_h1;

  assign d1 = (TAU_W+1)'(Q_ONE) - signed'({1'b0, tau4});
  assign y1 = d1[Y_W-1:0];

  vrf_horner #(.SB_W(SB1_W)) u_h1 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v4), .y(y1), .seg(SEG_MID),
    .sb({seg4, x4, tau4}), .out_valid(vh1), .acc(n_h1), .sb_out(sb_h1)
  );

  // shared divider: 1/tau, n/tau, or the far-segment 1/x
  seg_t             seg_h1;
  logic [63:0]      x_h1, num, den;
  logic [TAU_W-1:0] tau_h1;
  logic [ACC_W-2:0] nc;

  assign seg_h1 = seg_t'(sb_h1[SB1_W-1 -: 3]);
  assign x_h1   = sb_h1[TAU_W +: 64];
  assign tau_h1 = sb_h1[TAU_W-1:0];
  assign nc     = n_h1[ACC_W-1] ? '0 : n_h1[ACC_W-2:0];

  always_comb begin
    case (seg_h1)
      SEG_FAR: begin
        num = (64'd1 << (OUT_FRAC_BITS + QB)) + (x_h1 >> 1);
        den = x_h1;
      end
      SEG_MID: begin
        num = (64'(nc) << QB) + 64'(tau_h1 >> 1);
        den = 64'(tau_h1);
      end
      default: begin
        num = (64'd1 << (2 * QB)) + 64'(tau_h1 >> 1);
        den = 64'(tau_h1);
      end
    endcase
  end

  logic             vd;
  logic [QW-1:0]    q_d;
  logic [SBD_W-1:0] sb_d;

  vrf_div #(.SB_W(SBD_W)) u_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vh1), .num(num), .den(den),
    .sb({seg_h1, tau_h1}), .out_valid(vd), .quo(q_d), .sb_out(sb_d)
  );

  // main polynomial; the middle segment's quotient rides alongside as E
  seg_t               seg_d;
  logic [TAU_W-1:0]   tau_d;
  logic signed [TAU_W-1:0] diff;
  y_t                 y2;
  logic [ALPHA_W-1:0] alpha_far;

  assign seg_d     = seg_t'(sb_d[SBD_W-1 -: 3]);
  assign tau_d     = sb_d[TAU_W-1:0];
  assign diff      = signed'({1'b0, q_d}) - centre(seg_d);
  assign alpha_far = (q_d > ONE_Q) ? ONE_A : q_d[ALPHA_W-1:0];

  always_comb begin
    case (seg_d)
      SEG_LOW: y2 = tau_d[Y_W-1:0];
      default: y2 = diff[Y_W-1:0];
    endcase
  end

  logic             vh2;
  acc_t             e_h2;
  logic [SB2_W-1:0] sb_h2;

  vrf_horner #(.SB_W(SB2_W)) u_h2 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vd), .y(y2), .seg(seg_d),
    .sb({seg_d == SEG_MID, q_d, seg_d == SEG_FAR, alpha_far}),
    .out_valid(vh2), .acc(e_h2), .sb_out(sb_h2)
  );

  // clamp, scale, square root
  acc_t          e_sel;
  logic [QB:0]   ec;
  logic [VW-1:0] v_sq;

  assign e_sel = sb_h2[SB2_W-1] ? ACC_W'(sb_h2[SBF_W +: QW]) : e_h2;

  always_comb begin
    if (e_sel < 0) begin
      ec = '0;
    end else if (e_sel > Q_ONE) begin
      ec = Q_ONE[QB:0];
    end else begin
      ec = e_sel[QB:0];
    end
  end

  if (SQ_S >= 0) begin : g_up
    assign v_sq = VW'(ec) << SQ_S;
  end else begin : g_dn
    assign v_sq = VW'(ec >> (-SQ_S));
  end

  logic               vs;
  logic [ALPHA_W-1:0] root;
  logic [SBF_W-1:0]   sb_s;

  vrf_sqrt #(.RB(ALPHA_W), .SB_W(SBF_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vh2), .v(v_sq), .sb(sb_h2[SBF_W-1:0]),
    .out_valid(vs), .root(root), .sb_out(sb_s)
  );

  logic [ALPHA_W-1:0] alpha_next;
  assign alpha_next = sb_s[SBF_W-1] ? sb_s[ALPHA_W-1:0] :
                      ((root > ONE_A) ? ONE_A : root);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.alpha <= alpha_next;
    end
  end

  `VRF_ASSERT_IMP(a_ready_map, clk, rst, 1'b1, item.ready == (!result.valid || result.ready))
  `VRF_ASSERT_IMP(a_alpha_max, clk, rst, result.valid, result.alpha <= ONE_A)
  `VRF_ASSERT_NXT(a_front_hold, clk, rst, !item.ready, $stable(tau4) && $stable(v4))
endmodule

// File: sim/vrf_result_checker.sv
// Result checker for velocity_reduction_factor_core: watches both channels, predicts alpha.
// Depends on vrf_in_if and vrf_out_if.
`timescale 1ns / 1ps
module vrf_result_checker (
  input  logic clk,
  input  logic rst,
  vrf_in_if    item,
  vrf_out_if   result,
  output int   errors,
  output int   pending
);
  localparam int OUT_FB = 16;
  localparam longint unsigned TAU_B1 = 64'd616730209;
  localparam longint unsigned TAU_B2 = 64'd1610612736;
  localparam longint unsigned TAU_B3 = 64'd2684354560;
  localparam longint unsigned TAU_B4 = 64'd5657231867;
  localparam longint unsigned TAU_B5 = 64'd12252549135;
  localparam longint ONE_Q = 64'sd1073741824;

  logic [16:0] alpha_q[$];

  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, m;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    m = (ua * ub + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint poly_eval(longint c0, longint c1, longint c2, longint c3,
                                       longint c4, longint y);
    longint acc;
    acc = c4;
    acc = fx_mul(acc, y) + c3;
    acc = fx_mul(acc, y) + c2;
    acc = fx_mul(acc, y) + c1;
    acc = fx_mul(acc, y) + c0;
    return acc;
  endfunction

  function automatic longint unsigned round_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  function automatic logic [16:0] predict_alpha(logic [31:0] sigma, logic [31:0] ds);
    longint unsigned p, q, x, tau, alpha, rcp;
    longint e, n;
    p = longint'(sigma) * longint'(ds);
    q = p >> 2;
    x = (q > 64'hFFFF_FFFF_FFFF_FFFF / 10) ? 64'hFFFF_FFFF_FFFF_FFFF : q * 10;
    tau = 0;
    if (x < (64'd4 << 30)) tau = (x * x + (64'd1 << 29)) >> 30;
    if (x >= (64'd4 << 30) || tau >= TAU_B5) begin
      alpha = ((64'd1 << (OUT_FB + 30)) + (x >> 1)) / x;
    end else begin
      if (tau < TAU_B1) begin
        e = poly_eval(1073741824, -536870912, 178956971, -44739243, 8947849, tau);
      end else if (tau < TAU_B2) begin
        n = poly_eval(678734282, 395007542, -197503771, 65835924, -16458981,
                      ONE_Q - longint'(tau));
        if (n < 0) n = 0;
        e = longint'(((longint'(n) << 30) + (tau >> 1)) / tau);
      end else begin
        rcp = ((64'd1 << 60) + (tau >> 1)) / tau;
        if (tau < TAU_B3)
          e = poly_eval(464213335, 637796362, -581260615, 387507077, 0,
                        longint'(rcp) - 536870912);
        else if (tau < TAU_B4)
          e = poly_eval(297519323, 927832953, -695093649, -405471295, 64'sd2660905376,
                        longint'(rcp) - 306783378);
        else
          e = poly_eval(134172703, 1070500022, -92211265, -1229483533, -64'sd5901520961,
                        longint'(rcp) - 134217728);
      end
      if (e < 0) e = 0;
      if (e > ONE_Q) e = ONE_Q;
      alpha = round_sqrt(longint'(e) << (2 * OUT_FB - 30));
    end
    if (alpha > (64'd1 << OUT_FB)) alpha = 64'd1 << OUT_FB;
    return alpha[16:0];
  endfunction

  initial errors = 0;
  assign pending = alpha_q.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (item.valid && item.ready)
        alpha_q.push_back(predict_alpha(item.sigma, item.ds));
      if (result.valid && result.ready) begin
        if (alpha_q.size() == 0) begin
          $display("%0t: unexpected alpha transfer: expected none, actual %0d",
                   $time, result.alpha);
          errors++;
        end else if (alpha_q[0] !== result.alpha) begin
          $display("%0t: alpha mismatch: expected %0d, actual %0d",
                   $time, alpha_q[0], result.alpha);
          errors++;
          void'(alpha_q.pop_front());
        end else begin
          void'(alpha_q.pop_front());
        end
      end
    end
  end
endmodule

// File: sim/velocity_reduction_factor_core_test.sv
// Testbench top for velocity_reduction_factor_core: directed and random sigma/ds
// transfers under four idling phases. Depends on vrf_in_if, vrf_out_if, vrf_result_checker.
`timescale 1ns / 1ps
module velocity_reduction_factor_core_test;
  localparam int LIMIT = 600000;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending, cycles = 0;
  int   send_idle = 0, recv_stall = 0, n_sent = 0;

  vrf_in_if item_ch();
  vrf_out_if #(.ALPHA_W(17)) result_ch();

  velocity_reduction_factor_core dut (.clk(clk), .rst(rst), .item(item_ch), .result(result_ch));
  vrf_result_checker chk (.clk(clk), .rst(rst), .item(item_ch), .result(result_ch),
                          .errors(errors), .pending(pending));

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    item_ch.valid = 0;
    item_ch.sigma = 0;
    item_ch.ds = 0;
    result_ch.ready = 0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall);
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(logic [31:0] s, logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 0;
      @(posedge clk);
    end
    item_ch.valid <= 1;
    item_ch.sigma <= s;
    item_ch.ds <= d;
    do @(posedge clk); while (!item_ch.ready);
    n_sent++;
  endtask

  task automatic send_random();
    logic [31:0] s, d, target;
    case ($urandom_range(9))
      0, 1, 2: begin
        s = $urandom >> $urandom_range(31);
        d = $urandom >> $urandom_range(31);
      end
      default: begin
        s = $urandom_range(1, 32'h0010_0000);
        target = $urandom_range(0, 32'h8000_0000);
        d = target / s;
      end
    endcase
    send(s, d);
  endtask

  initial begin
    int bp_ds[6] = '{4967, 8026, 10362, 15043, 22139, 26214};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(0, 0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(0, 32'hFFFF_FFFF);
    send(32'hFFFF_FFFF, 0);
    send(1, 1);
    send(32'h0001_0000, 32'h0001_0000);
    send(32'hFFFF_FFFF, 1);
    foreach (bp_ds[i]) begin
      send(32'h0001_0000, bp_ds[i] - 1);
      send(32'h0001_0000, bp_ds[i]);
      send(32'h0001_0000, bp_ds[i] + 1);
    end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      repeat (212) send_random();
    end
    item_ch.valid <= 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("sent %0d sigma/ds transfers across all tau segments, saturation and zero cases,",
             n_sent);
    $display("with sender gaps and receiver stalls in four phases");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
